// ----- design/npca_pkg.sv -----
`default_nettype none

package npca_pkg;

    // Palette geometry. The attribute byte holds two 4-bit indexes.
    localparam int MAX_ENTRIES         = 16;
    localparam int PALETTE_ENTRIES_DEF = 16;
    localparam int IDX_W               = 4;
    localparam int CHAN_W              = 8;
    localparam int COLOR_W             = 3 * CHAN_W;
    localparam int SQ_W                = 2 * CHAN_W;
    // Three squared channel differences of at most 255*255 each fit in 18 bits.
    localparam int DIST_W              = SQ_W + 2;

    // Configuration registers: each holds two colors, at bits 0-23 and 32-55.
    localparam int PAIR_COUNT  = 8;
    localparam int PAIR_W      = 56;
    localparam int CFG_INDEX_W = 4;
    localparam int HI_LSB      = 32;

    typedef logic [DIST_W-1:0] dist_t;
    typedef logic [IDX_W-1:0]  idx_t;

    // Packed as 0xBBGGRR: red sits in the low byte.
    typedef struct packed {
        logic [CHAN_W-1:0] blue;
        logic [CHAN_W-1:0] green;
        logic [CHAN_W-1:0] red;
    } rgb_t;

    // Default 16-color console palette, two entries per register.
    localparam logic [PAIR_W-1:0] PAIR_RESET [PAIR_COUNT] = '{
        56'd36028797018963968,
        56'd36169534507352064,
        56'd36029346774777984,
        56'd54255126394732672,
        56'd71776119069638784,
        56'd72056494526365440,
        56'd71777214277878015,
        56'd72057589743026175
    };

    // Square of the absolute difference of two channel values.
    function automatic logic [SQ_W-1:0] sq_diff(
        input logic [CHAN_W-1:0] a,
        input logic [CHAN_W-1:0] b
    );
        logic [CHAN_W-1:0] d;
        begin
            d = (a > b) ? (a - b) : (b - a);
            sq_diff = SQ_W'(d) * SQ_W'(d);
        end
    endfunction

endpackage

`default_nettype wire

// ----- design/npca_palette.sv -----
`default_nettype none

// Palette register file: eight write-only pair registers, reset to the
// console palette, presented as sixteen colors.
module npca_palette (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               cfg_valid,
    input  wire logic [npca_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  wire logic [npca_pkg::PAIR_W-1:0]        cfg_data,
    output logic                                    cfg_ready,
    output npca_pkg::rgb_t                          palette [npca_pkg::MAX_ENTRIES]
);

    npca_pkg::rgb_t entry_reg [npca_pkg::MAX_ENTRIES];
    logic           wr_en;

    assign cfg_ready = 1'b1;
    assign wr_en     = cfg_valid && cfg_ready;

    for (genvar k = 0; k < npca_pkg::PAIR_COUNT; k++) begin : g_pair
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                entry_reg[2*k]   <= npca_pkg::PAIR_RESET[k][npca_pkg::COLOR_W-1:0];
                entry_reg[2*k+1] <= npca_pkg::PAIR_RESET[k][npca_pkg::HI_LSB +:
                                                            npca_pkg::COLOR_W];
            end
            else if (wr_en && cfg_index == npca_pkg::CFG_INDEX_W'(k))
            begin
                // Bits 24-31 of the written word are dropped.
                entry_reg[2*k]   <= cfg_data[npca_pkg::COLOR_W-1:0];
                entry_reg[2*k+1] <= cfg_data[npca_pkg::HI_LSB +: npca_pkg::COLOR_W];
            end
        end
    end

    assign palette = entry_reg;

endmodule

`default_nettype wire

// ----- design/npca_dist.sv -----
`default_nettype none

// Squared Euclidean distance from one color to each active palette entry,
// registered.
module npca_dist #(
    parameter int ENTRIES = npca_pkg::PALETTE_ENTRIES_DEF
) (
    input  wire logic            clk,
    input  wire npca_pkg::rgb_t  color,
    input  wire npca_pkg::rgb_t  palette [npca_pkg::MAX_ENTRIES],
    output npca_pkg::dist_t      distance [ENTRIES]
);

    npca_pkg::dist_t dist_next [ENTRIES];
    npca_pkg::dist_t dist_reg  [ENTRIES];

    for (genvar i = 0; i < ENTRIES; i++) begin : g_entry
        always_comb
        begin
            dist_next[i] =
                npca_pkg::DIST_W'(npca_pkg::sq_diff(color.red,   palette[i].red))
              + npca_pkg::DIST_W'(npca_pkg::sq_diff(color.green, palette[i].green))
              + npca_pkg::DIST_W'(npca_pkg::sq_diff(color.blue,  palette[i].blue));
        end

        always_ff @(posedge clk)
        begin
            dist_reg[i] <= dist_next[i];
        end
    end

    assign distance = dist_reg;

endmodule

`default_nettype wire

// ----- design/npca_argmin.sv -----
`default_nettype none

// Four-level compare tree that finds the smallest distance. The left child
// always covers lower indexes, so it is kept unless the right one is
// strictly smaller; this gives the lowest index on a tie.
module npca_argmin #(
    parameter int ENTRIES = npca_pkg::PALETTE_ENTRIES_DEF
) (
    input  wire npca_pkg::dist_t  distance [ENTRIES],
    output npca_pkg::idx_t        index
);

    localparam int NODES = 2 * npca_pkg::MAX_ENTRIES - 1;
    localparam int FIRST_LEAF = npca_pkg::MAX_ENTRIES - 1;

    npca_pkg::dist_t node_dist [NODES];
    npca_pkg::idx_t  node_idx  [NODES];

    // Unused leaves carry the all-ones distance, which no real color reaches.
    for (genvar j = 0; j < npca_pkg::MAX_ENTRIES; j++) begin : g_leaf
        if (j < ENTRIES) begin : g_used
            assign node_dist[FIRST_LEAF + j] = distance[j];
        end
        else begin : g_pad
            assign node_dist[FIRST_LEAF + j] = '1;
        end
        assign node_idx[FIRST_LEAF + j] = npca_pkg::IDX_W'(j);
    end

    for (genvar n = 0; n < FIRST_LEAF; n++) begin : g_node
        logic right_wins;
        assign right_wins   = node_dist[2*n+2] < node_dist[2*n+1];
        assign node_dist[n] = right_wins ? node_dist[2*n+2] : node_dist[2*n+1];
        assign node_idx[n]  = right_wins ? node_idx[2*n+2]  : node_idx[2*n+1];
    end

    assign index = node_idx[0];

endmodule

`default_nettype wire

// ----- design/nearest_palette_cell_attribute_core.sv -----
`default_nettype none

// Path: a transferred cell is captured in stage 1, its distances in stage 2 and its result
// in stage 3, which drives the result ports, where the receiver takes it.
// Throughput: one cell per clock; busy stays low, and results leave as a strobe the
// receiver cannot stall, so the pipeline never holds.
// Reset (rst_n low, asynchronous): pipeline valid flags clear and the palette returns
// to the default 16-color console palette.
module nearest_palette_cell_attribute_core #(
    parameter int PALETTE_ENTRIES = npca_pkg::PALETTE_ENTRIES_DEF
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,

    // Cell input. A transfer happens on an edge with start high and busy low.
    input  wire logic                               start,
    output logic                                    busy,
    input  wire logic [7:0]                         glyph,
    input  wire logic [7:0]                         fg_red,
    input  wire logic [7:0]                         fg_green,
    input  wire logic [7:0]                         fg_blue,
    input  wire logic [7:0]                         bg_red,
    input  wire logic [7:0]                         bg_green,
    input  wire logic [7:0]                         bg_blue,
    input  wire logic                               frame_last,

    // Result output, valid for exactly the one cycle that result_valid is high.
    output logic                                    result_valid,
    output logic [7:0]                              glyph_out,
    output logic [7:0]                              attribute,
    output logic                                    frame_last_out,

    // Palette register writes.
    input  wire logic                               cfg_valid,
    output logic                                    cfg_ready,
    input  wire logic [npca_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  wire logic [npca_pkg::PAIR_W-1:0]        cfg_data
);

    // The pipeline has three register stages:
    //   stage 1 captures the accepted cell,
    //   stage 2 holds the distances from both colors to every palette entry,
    //   stage 3 holds the finished result, driven straight onto the ports.
    // Nothing stalls, so every stage just loads each cycle and a valid flag
    // follows the cell down the pipe.

    npca_pkg::rgb_t  palette [npca_pkg::MAX_ENTRIES];

    // Stage 1 registers.
    logic            s1_valid_reg;
    logic [7:0]      s1_glyph_reg;
    logic            s1_last_reg;
    npca_pkg::rgb_t  s1_fg_reg;
    npca_pkg::rgb_t  s1_bg_reg;

    // Stage 2 registers (the distances themselves live in the distance units).
    logic            s2_valid_reg;
    logic [7:0]      s2_glyph_reg;
    logic            s2_last_reg;
    npca_pkg::dist_t fg_dist [PALETTE_ENTRIES];
    npca_pkg::dist_t bg_dist [PALETTE_ENTRIES];

    // Stage 3 registers.
    logic            out_valid_reg;
    logic [7:0]      out_glyph_reg;
    logic [7:0]      out_attr_reg;
    logic            out_last_reg;

    npca_pkg::idx_t  fg_index;
    npca_pkg::idx_t  bg_index;
    logic            accept;

    // The pipeline never has to hold, so a new cell is taken in every cycle.
    assign busy   = 1'b0;
    assign accept = start && !busy;

    npca_palette u_palette (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg_ready (cfg_ready),
        .palette   (palette)
    );

    // Valid flags are control state and are cleared by reset.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= accept;
            s2_valid_reg  <= s1_valid_reg;
            out_valid_reg <= s2_valid_reg;
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge clk)
    begin
        s1_glyph_reg <= glyph;
        s1_last_reg  <= frame_last;
        s1_fg_reg    <= '{blue: fg_blue, green: fg_green, red: fg_red};
        s1_bg_reg    <= '{blue: bg_blue, green: bg_green, red: bg_red};

        s2_glyph_reg <= s1_glyph_reg;
        s2_last_reg  <= s1_last_reg;

        out_glyph_reg <= s2_glyph_reg;
        out_last_reg  <= s2_last_reg;
        out_attr_reg  <= {bg_index, fg_index};
    end

    // Distance units form stage 2; each registers one distance per entry.
    npca_dist #(
        .ENTRIES (PALETTE_ENTRIES)
    ) u_fg_dist (
        .clk      (clk),
        .color    (s1_fg_reg),
        .palette  (palette),
        .distance (fg_dist)
    );

    npca_dist #(
        .ENTRIES (PALETTE_ENTRIES)
    ) u_bg_dist (
        .clk      (clk),
        .color    (s1_bg_reg),
        .palette  (palette),
        .distance (bg_dist)
    );

    // The compare trees sit between stage 2 and the result register.
    npca_argmin #(
        .ENTRIES (PALETTE_ENTRIES)
    ) u_fg_min (
        .distance (fg_dist),
        .index    (fg_index)
    );

    npca_argmin #(
        .ENTRIES (PALETTE_ENTRIES)
    ) u_bg_min (
        .distance (bg_dist),
        .index    (bg_index)
    );

    assign result_valid   = out_valid_reg;
    assign glyph_out      = out_glyph_reg;
    assign attribute      = out_attr_reg;
    assign frame_last_out = out_last_reg;

    // Every result comes from an earlier cell transfer.
    a_result_has_cell: assert property (
        @(posedge clk) disable iff (!rst_n)
        result_valid |-> $past(start, 3)
    ) else $error("result without a cell transfer three cycles before");

    // The character and frame marker travel alongside the cell unchanged.
    a_passthrough: assert property (
        @(posedge clk) disable iff (!rst_n)
        result_valid |-> (glyph_out == $past(glyph, 3)
                          && frame_last_out == $past(frame_last, 3))
    ) else $error("glyph or frame marker lost its alignment with the result");

    // Only active palette entries can be chosen.
    a_index_in_range: assert property (
        @(posedge clk) disable iff (!rst_n)
        result_valid |-> (int'(attribute[3:0]) < PALETTE_ENTRIES
                          && int'(attribute[7:4]) < PALETTE_ENTRIES)
    ) else $error("attribute names a palette entry outside the active range");

endmodule

`default_nettype wire
